>>> rtl/core/krt_pkg.sv
// Package for the kana reading to UTF-8 transcoder.
// Holds the command and result codes, byte constants and the job record.
// No dependencies.
`default_nettype none

package krt_pkg;

  typedef enum logic {
    CMD_TEXT   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0] UTF8_CONT   = 8'h80;
  localparam logic [5:0] UTF8_MASK6  = 6'h3F;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;
  localparam logic [7:0] CHAR_EXCL   = 8'h21;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_TILDE  = 8'h7E;
  localparam logic [15:0] KATA_SHIFT = 16'h0060;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // One queued job: up to four bytes, or one summary. bytes[0] goes out first.
  typedef struct packed {
    kind_e           kind;
    logic [1:0]      nlast;
    logic [3:0][7:0] bytes;
    logic            nonempty;
    logic [15:0]     skipped;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/krt_in_if.sv
// Input channel of the transcoder: valid/ready plus command and code point.
// Depends on nothing.
`default_nettype none

interface krt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [20:0] code_point;

  modport source (output valid, cmd, code_point, input ready);
  modport sink   (input valid, cmd, code_point, output ready);
endinterface

`default_nettype wire

>>> rtl/core/krt_out_if.sv
// Output channel of the transcoder: valid/ready plus one result beat.
// Depends on nothing.
`default_nettype none

interface krt_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        last;
  logic        nonempty;
  logic [15:0] skipped_count;

  modport source (output valid, kind, out_byte, last, nonempty, skipped_count, input ready);
  modport sink   (input valid, kind, out_byte, last, nonempty, skipped_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/kana_reading_to_utf8_transcoder.sv
// Kana reading to UTF-8 transcoder, top level.
// Channels: in_ch_i takes one item per beat (cmd = text with a code point, or
// finish); out_ch_o gives one beat per UTF-8 byte, or one summary beat for a
// finish, with last set on the final beat caused by an item.
// An item with no output (skipped, dropped, boundary) is absorbed silently.
// With the output side idle, a taken item is first written into the job queue,
// then loaded into the byte sender, whose register drives the first beat.
// Throughput: one input item per cycle while the job queue has room; the output
// runs at one beat per cycle while the receiver is ready and jobs wait, and an
// item has 1 to 4 beats (a pending '#' plus up to three bytes). The back end's
// single byte lane sets the sustained rate.
// The classifier and the byte sender are decoupled by a QUEUE_DEPTH job queue:
// when the receiver stalls the sender holds its beat and the classifier keeps
// taking items until the queue fills, then drops its ready.
// Reset clears the text state, the skip tally, the queue and the sender.
// Depends on krt_pkg, krt_in_if, krt_out_if, krt_front, krt_queue, krt_back.
`default_nettype none

module kana_reading_to_utf8_transcoder import krt_pkg::*; #(
  parameter int unsigned SKIP_COUNT_BITS = 16,
  parameter int unsigned QUEUE_DEPTH     = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  krt_in_if.sink    in_ch_i,
  krt_out_if.source out_ch_o
);

  job_t push_job, head_job;
  logic push, push_ready, pop, head_valid;

  krt_front #(
    .SKIP_COUNT_BITS(SKIP_COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch_i     (in_ch_i),
    .job_o       (push_job),
    .push_o      (push),
    .push_ready_i(push_ready)
  );

  krt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .head_o      (head_job),
    .head_valid_o(head_valid)
  );

  krt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .out_ch_o    (out_ch_o)
  );

`ifndef SYNTH
  a_summary_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && (out_ch_o.kind == KIND_SUMMARY) |-> out_ch_o.last &&
    (out_ch_o.out_byte == 8'h00))
    else $error("summary beat not single and clean");

  a_byte_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && (out_ch_o.kind == KIND_BYTE) |->
    !out_ch_o.nonempty && (out_ch_o.skipped_count == 16'h0000))
    else $error("byte beat carries summary fields");

  a_pop_has_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("sender took a job from an empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/core/krt_front.sv
// Front end: accepts code points, classifies them, tracks text state and
// builds one job per item that has results. Depends on krt_pkg, krt_in_if.
`default_nettype none

module krt_front import krt_pkg::*; #(
  parameter int unsigned SKIP_COUNT_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  krt_in_if.sink    in_ch_i,
  output job_t      job_o,
  output logic      push_o,
  input  wire logic push_ready_i
);

  logic                       wrote_any_q, wrote_any_d;
  logic                       bnd_pend_q, bnd_pend_d;
  logic                       q_open_q, q_open_d;
  logic [SKIP_COUNT_BITS-1:0] tally_q, tally_d;

  logic                        accept;
  logic [15:0]                 cp16;
  logic [15:0]                 kata16;
  logic [7:0]                  sfx;
  logic [2:0][7:0]             dat;
  logic [1:0]                  ndat;
  logic                        add_hash;
  logic [SKIP_COUNT_BITS+15:0] tally_ext;
  logic [15:0]                 tally_sat;

  assign accept          = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready   = push_ready_i;
  assign cp16            = in_ch_i.code_point[15:0];
  assign kata16          = cp16 - KATA_SHIFT;
  assign tally_ext       = {16'h0000, tally_q};
  assign tally_sat       = (|tally_ext[SKIP_COUNT_BITS+15:16]) ? COUNT_MAX : tally_ext[15:0];

  always_comb begin
    case (in_ch_i.code_point) inside
      21'h000021, 21'h00FF01: sfx = CHAR_EXCL;
      21'h00002E, 21'h00FF0E: sfx = CHAR_DOT;
      21'h00007E, 21'h00FF5E: sfx = CHAR_TILDE;
      default:                sfx = 8'h00;
    endcase
  end

  always_comb begin
    dat         = '0;
    ndat        = 2'd0;
    wrote_any_d = wrote_any_q;
    bnd_pend_d  = bnd_pend_q;
    q_open_d    = 1'b0;
    tally_d     = tally_q;
    add_hash    = 1'b0;
    job_o       = '0;

    if (in_ch_i.cmd == CMD_FINISH) begin
      job_o.kind     = KIND_SUMMARY;
      job_o.nonempty = wrote_any_q;
      job_o.skipped  = tally_sat;
      wrote_any_d    = 1'b0;
      bnd_pend_d     = 1'b0;
      tally_d        = '0;
    end else begin
      if (q_open_q && (sfx != 8'h00)) begin
        dat[0] = sfx;
        ndat   = 2'd1;
      end else begin
        case (in_ch_i.code_point) inside
          [21'h003041:21'h003096], 21'h0030FC: begin
            dat[0] = UTF8_LEAD3 | {4'h0, cp16[15:12]};
            dat[1] = UTF8_CONT | {2'b00, cp16[11:6]};
            dat[2] = UTF8_CONT | {2'b00, cp16[5:0] & UTF8_MASK6};
            ndat   = 2'd3;
          end
          [21'h0030A1:21'h0030F6]: begin
            dat[0] = UTF8_LEAD3 | {4'h0, kata16[15:12]};
            dat[1] = UTF8_CONT | {2'b00, kata16[11:6]};
            dat[2] = UTF8_CONT | {2'b00, kata16[5:0] & UTF8_MASK6};
            ndat   = 2'd3;
          end
          21'h000027, 21'h002019: begin
            dat[0] = CHAR_RBRACK;
            ndat   = 2'd1;
          end
          21'h00002F, 21'h003001, 21'h003002, 21'h00FF0C, 21'h00002C, 21'h00FF0E,
          21'h00002E, 21'h000023, 21'h000020, 21'h003000, 21'h00000A, 21'h00000D,
          21'h000009: begin
            if (wrote_any_q) bnd_pend_d = 1'b1;
          end
          21'h00003F, 21'h00FF1F: begin
            dat[0]   = CHAR_QMARK;
            ndat     = 2'd1;
            q_open_d = 1'b1;
          end
          21'h000021, 21'h00FF01: begin
            ndat = 2'd0;
          end
          21'h0000B0: begin
            dat[0] = UTF8_LEAD2 | {2'b00, cp16[11:6]};
            dat[1] = UTF8_CONT | {2'b00, cp16[5:0] & UTF8_MASK6};
            ndat   = 2'd2;
          end
          21'h00005B, 21'h00005D, 21'h00005F, 21'h00005E, 21'h000024: begin
            dat[0] = cp16[7:0];
            ndat   = 2'd1;
          end
          default: begin
            if (tally_q != '1) tally_d = tally_q + 1'b1;
          end
        endcase
      end

      if (ndat != 2'd0) begin
        add_hash    = bnd_pend_q && wrote_any_q;
        bnd_pend_d  = 1'b0;
        wrote_any_d = 1'b1;
      end

      job_o.kind = KIND_BYTE;
      if (add_hash) begin
        job_o.bytes = {dat[2], dat[1], dat[0], CHAR_HASH};
        job_o.nlast = ndat;
      end else begin
        job_o.bytes = {8'h00, dat[2], dat[1], dat[0]};
        job_o.nlast = ndat - 2'd1;
      end
    end
  end

  assign push_o = accept && ((in_ch_i.cmd == CMD_FINISH) || (ndat != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrote_any_q <= 1'b0;
      bnd_pend_q  <= 1'b0;
      q_open_q    <= 1'b0;
      tally_q     <= '0;
    end else if (accept) begin
      wrote_any_q <= wrote_any_d;
      bnd_pend_q  <= bnd_pend_d;
      q_open_q    <= q_open_d;
      tally_q     <= tally_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/krt_queue.sv
// Short job queue between front and back end, in flip-flops.
// Depends on krt_pkg.
`default_nettype none

module krt_queue import krt_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  output logic      push_ready_o,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      head_valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/krt_back.sv
// Back end: takes jobs from the queue and sends their bytes one beat at a time.
// Depends on krt_pkg, krt_out_if.
`default_nettype none

module krt_back import krt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t head_i,
  input  wire logic head_valid_i,
  output logic      pop_o,
  krt_out_if.source out_ch_o
);

  job_t       cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       fire, at_last;

  assign at_last = idx_q == cur_q.nlast;
  assign fire    = busy_q && out_ch_o.ready;
  // reload when idle or while the final beat of the current job leaves
  assign pop_o   = head_valid_i && (!busy_q || (fire && at_last));

  assign out_ch_o.valid         = busy_q;
  assign out_ch_o.kind          = cur_q.kind;
  assign out_ch_o.out_byte      = cur_q.bytes[idx_q];
  assign out_ch_o.last          = at_last;
  assign out_ch_o.nonempty      = cur_q.nonempty;
  assign out_ch_o.skipped_count = cur_q.skipped;

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (fire) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire
